>>> hdl/strs_pkg.sv
// Shared constants for the segment tree range-sum block.
package strs_pkg;

   localparam int LEAVES_DEFAULT    = 1024;
   localparam int USED_LENGTH_RESET = 1024;
   localparam int SUM_W             = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

>>> hdl/segment_tree_range_sum.sv
// Segment tree of wrapping 32-bit partial sums with point writes and range-sum queries.
//
// After reset the block zeroes all 2*LEAVES words of its node memory in a clearing pass,
// with req_ready low; csr writes are taken at any time. The tree lives in one memory of
// 2*LEAVES words with one write port and one read port whose read data is registered.
// A write request writes the leaf in the accept cycle, then one parent is summed and
// written per cycle while the sibling of that parent is read, up to the root. A query
// request walks the levels bottom-up; at each level it may add the node at the left
// end and the node at the right end, each read in its own step, and then climbs one
// level. The single read port is why the nodes are read one at a time. Queries that
// are empty after clipping skip the walk and go straight to the output state. One
// request is in flight at a time; a finished sum waits in the output register, and
// the next request is accepted once that sum has been loaded there.
module segment_tree_range_sum
   import strs_pkg::*;
#(
   parameter int LEAVES = LEAVES_DEFAULT,
   localparam int IDX_W = $clog2(LEAVES)
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [IDX_W:0]          csr_used_length,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [IDX_W-1:0]        req_elem_index,
   input  logic signed [SUM_W-1:0] req_new_value,
   input  logic [IDX_W-1:0]        req_range_left,
   input  logic [IDX_W-1:0]        req_range_right,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_range_sum
);

   localparam int NODE_W = IDX_W + 1;
   localparam int A_W    = IDX_W + 2;
   localparam int DEPTH  = 2 * LEAVES;
   localparam int USED_RESET = (LEAVES < USED_LENGTH_RESET) ? LEAVES : USED_LENGTH_RESET;

   localparam logic [A_W-1:0]    LEAF_BASE_A = A_W'(LEAVES);
   localparam logic [NODE_W-1:0] LEAF_BASE_N = NODE_W'(LEAVES);
   localparam logic [NODE_W-1:0] ROOT_NODE   = NODE_W'(1);
   localparam logic [NODE_W-1:0] LAST_NODE   = NODE_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_UP,
      ST_QUERY,
      ST_Q_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [IDX_W:0]     used_length_ff, used_length_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [SUM_W-1:0]   cur_ff, cur_in;
   logic [A_W-1:0]     a_ff, a_in;
   logic [A_W-1:0]     b_ff, b_in;
   logic               pend_ff, pend_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic [SUM_W-1:0]   mem [DEPTH];
   logic [SUM_W-1:0]   rd_data_ff;
   logic               mem_we;
   logic [NODE_W-1:0]  mem_wa;
   logic [SUM_W-1:0]   mem_wd;
   logic [NODE_W-1:0]  mem_ra;

   logic [IDX_W:0]     eff_len;
   logic [IDX_W:0]     hi_clip;
   logic [IDX_W:0]     lo_ext;
   logic [NODE_W-1:0]  leaf;
   logic [NODE_W-1:0]  parent;
   logic [SUM_W-1:0]   parent_sum;
   logic [SUM_W-1:0]   addend;
   logic [A_W-1:0]     b_dec;

   assign csr_ready     = 1'b1;
   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = signed'(rsp_sum_ff);

   always_comb begin
      eff_len    = (used_length_ff < (IDX_W + 1)'(LEAVES)) ? used_length_ff
                                                            : (IDX_W + 1)'(LEAVES);
      lo_ext     = {1'b0, req_range_left};
      hi_clip    = ({1'b0, req_range_right} > (eff_len - 1'b1)) ? (eff_len - 1'b1)
                                                                 : {1'b0, req_range_right};
      leaf       = LEAF_BASE_N | {1'b0, req_elem_index};
      parent     = node_ff >> 1;
      parent_sum = cur_ff + rd_data_ff;
      addend     = pend_ff ? rd_data_ff : '0;
      b_dec      = b_ff - 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      used_length_in = used_length_ff;
      node_in        = node_ff;
      cur_in         = cur_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      pend_in        = pend_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sum_in     = rsp_sum_ff;
      mem_we         = 1'b0;
      mem_wa         = node_ff;
      mem_wd         = parent_sum;
      mem_ra         = node_ff;

      if (csr_valid && csr_ready) begin
         used_length_in = csr_used_length;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  // Writes beyond the used length leave the tree untouched.
                  if ({1'b0, req_elem_index} < eff_len) begin
                     mem_we   = 1'b1;
                     mem_wa   = leaf;
                     mem_wd   = unsigned'(req_new_value);
                     mem_ra   = leaf ^ ROOT_NODE;
                     node_in  = leaf;
                     cur_in   = unsigned'(req_new_value);
                     state_in = ST_WR_UP;
                  end
               end else begin
                  acc_in  = '0;
                  pend_in = 1'b0;
                  a_in    = {1'b0, lo_ext} + LEAF_BASE_A;
                  b_in    = {1'b0, hi_clip} + LEAF_BASE_A + 1'b1;
                  if (eff_len == '0 || lo_ext > hi_clip) begin
                     state_in = ST_Q_OUT;
                  end else begin
                     state_in = ST_QUERY;
                  end
               end
            end
         end
         ST_WR_UP: begin
            // The sibling read last cycle is in rd_data_ff; fold it into the parent.
            mem_we  = 1'b1;
            mem_wa  = parent;
            mem_wd  = parent_sum;
            mem_ra  = parent ^ ROOT_NODE;
            node_in = parent;
            cur_in  = parent_sum;
            if (parent == ROOT_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            acc_in  = acc_ff + addend;
            pend_in = 1'b0;
            if (a_ff < b_ff) begin
               if (a_ff[0]) begin
                  mem_ra  = a_ff[NODE_W-1:0];
                  pend_in = 1'b1;
                  a_in    = a_ff + 1'b1;
               end else if (b_ff[0]) begin
                  mem_ra  = b_dec[NODE_W-1:0];
                  pend_in = 1'b1;
                  b_in    = b_dec;
               end else begin
                  a_in = a_ff >> 1;
                  b_in = b_ff >> 1;
               end
            end else begin
               state_in = ST_Q_OUT;
            end
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         used_length_ff <= (IDX_W + 1)'(USED_RESET);
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         used_length_ff <= used_length_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

endmodule
